// File: rtl/bsm_pkg.sv
package bsm_pkg;

	localparam int BSM_WIDTH = 16;

	typedef enum logic [1:0] {
		BOOTH_NONE = 2'd0,
		BOOTH_ADD  = 2'd1,
		BOOTH_SUB  = 2'd2
	} booth_op_t;

	// radix-2 recoding of the current bit and the bit scanned before it
	function automatic booth_op_t booth_op(input logic cur, input logic prev);
		booth_op_t op;
		case ({cur, prev})
			2'b10: begin
				op = BOOTH_SUB;
			end
			2'b01: begin
				op = BOOTH_ADD;
			end
			default: begin
				op = BOOTH_NONE;
			end
		endcase
		return op;
	endfunction

	typedef struct packed {
		logic valid;
		logic load;
	} stage_ctrl_t;

endpackage

// File: rtl/bsm_booth_stage.sv
module bsm_booth_stage
	import bsm_pkg::*;
#(
	parameter int WIDTH = BSM_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  stage_ctrl_t      ctrl,
	input  logic [WIDTH:0]   acc_in,
	input  logic [WIDTH-1:0] q_in,
	input  logic             prev_in,
	input  logic [WIDTH-1:0] mcand_in,
	output logic             valid,
	output logic [WIDTH:0]   acc_out,
	output logic [WIDTH-1:0] q_out,
	output logic             prev_out,
	output logic [WIDTH-1:0] mcand_out
);

	logic             valid_s1;
	logic [WIDTH:0]   acc_s1;
	logic [WIDTH-1:0] q_s1;
	logic             prev_s1;
	logic [WIDTH-1:0] mcand_s1;

	logic [WIDTH:0] mcand_ext;
	logic [WIDTH:0] sum;

	assign mcand_ext = {mcand_in[WIDTH-1], mcand_in};

	always_comb begin
		case (booth_op(q_in[0], prev_in))
			BOOTH_ADD: begin
				sum = acc_in + mcand_ext;
			end
			BOOTH_SUB: begin
				sum = acc_in - mcand_ext;
			end
			default: begin
				sum = acc_in;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctrl.load) begin
			valid_s1 <= ctrl.valid;
		end
	end

	// arithmetic shift right of the accumulator and multiplier pair
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_s1   <= {sum[WIDTH], sum[WIDTH:1]};
			q_s1     <= {sum[0], q_in[WIDTH-1:1]};
			prev_s1  <= q_in[0];
			mcand_s1 <= mcand_in;
		end
	end

	assign valid     = valid_s1;
	assign acc_out   = acc_s1;
	assign q_out     = q_s1;
	assign prev_out  = prev_s1;
	assign mcand_out = mcand_s1;

endmodule

// File: rtl/booth_signed_multiplier_unit.sv
// product valid: the item passes through every registered booth stage in order, from the accepting edge
// throughput: one item per cycle while out_stall is low, one booth step per pipeline stage
// stages hold their item under out_stall, empty stages still fill behind
// reset: arst_n asynchronous active low clears all stage valid bits
module booth_signed_multiplier_unit
	import bsm_pkg::*;
#(
	parameter int WIDTH = BSM_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [WIDTH-1:0]   multiplier,
	input  logic [WIDTH-1:0]   multiplicand,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2*WIDTH-1:0] product
);

	logic [WIDTH:0]   acc_p   [WIDTH+1];
	logic [WIDTH-1:0] q_p     [WIDTH+1];
	logic             prev_p  [WIDTH+1];
	logic [WIDTH-1:0] mcand_p [WIDTH+1];
	logic             valid_p [WIDTH+1];
	logic             ready_p [WIDTH+1];

	assign acc_p[0]   = '0;
	assign q_p[0]     = multiplier;
	assign prev_p[0]  = 1'b0;
	assign mcand_p[0] = multiplicand;
	assign valid_p[0] = in_valid;

	assign ready_p[WIDTH] = !out_stall;

	for (genvar i = 0; i < WIDTH; i++) begin : g_stage
		stage_ctrl_t ctrl;

		// a stage loads when it is empty or its item moves on
		assign ready_p[i]  = !valid_p[i+1] || ready_p[i+1];
		assign ctrl.valid  = valid_p[i];
		assign ctrl.load   = ready_p[i];

		bsm_booth_stage #(
			.WIDTH(WIDTH)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.acc_in   (acc_p[i]),
			.q_in     (q_p[i]),
			.prev_in  (prev_p[i]),
			.mcand_in (mcand_p[i]),
			.valid    (valid_p[i+1]),
			.acc_out  (acc_p[i+1]),
			.q_out    (q_p[i+1]),
			.prev_out (prev_p[i+1]),
			.mcand_out(mcand_p[i+1])
		);
	end

	assign in_stall  = !ready_p[0];
	assign out_valid = valid_p[WIDTH];
	assign product   = {acc_p[WIDTH][WIDTH-1:0], q_p[WIDTH]};

endmodule
